// ----- design/kdp_pkg.sv -----
// ============================================================================
// kdp_pkg: shared types and constants for the keyboard/display adapter
// Holds the word layouts, mode codes, register indexes and key mapping.
// ============================================================================
`default_nettype none

package kdp_pkg;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_KEY   = 2'd2
   } mode_type;

   localparam logic [1:0] REG_PORT_A = 2'd0;
   localparam logic [1:0] REG_CTRL_A = 2'd1;
   localparam logic [1:0] REG_PORT_B = 2'd2;
   localparam logic [1:0] REG_CTRL_B = 2'd3;

   // Bit 2 of a control register picks the data register over the direction register.
   localparam int CTRL_SEL_BIT = 2;

   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef struct packed {
      logic [7:0] data_in;
      logic [1:0] reg_select;
      logic [1:0] mode;
   } item_type;

   typedef struct packed {
      logic [6:0] display_char;
      logic       display_valid;
      logic [7:0] read_data;
   } result_type;

   function automatic logic [6:0] fold_key(input logic [7:0] raw);
      logic [7:0] k;
      k = raw;
      if (k >= LOWER_FIRST && k <= LOWER_LAST) begin
         k = k - CASE_OFFSET;
      end
      if (k == CHAR_LF) begin
         k = CHAR_CR;
      end
      return k[6:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/kdp_core.sv -----
// ============================================================================
// kdp_core: register file and access logic
// Holds the port and control registers and works out one bus access or key
// press per cycle with fire high: the result and register updates it causes.
// ============================================================================
`default_nettype none

module kdp_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire kdp_pkg::item_type   item,
   output kdp_pkg::result_type      result
);
   import kdp_pkg::*;

   logic [7:0] dir_a_ff, dir_a_in;
   logic [7:0] ctrl_a_ff, ctrl_a_in;
   logic [7:0] dir_b_ff, dir_b_in;
   logic [7:0] ctrl_b_ff, ctrl_b_in;
   logic [7:0] out_b_ff, out_b_in;
   logic [6:0] key_code_ff, key_code_in;
   logic       key_pending_ff, key_pending_in;
   logic       disp_ready_ff, disp_ready_in;

   always_comb begin
      dir_a_in       = dir_a_ff;
      ctrl_a_in      = ctrl_a_ff;
      dir_b_in       = dir_b_ff;
      ctrl_b_in      = ctrl_b_ff;
      out_b_in       = out_b_ff;
      key_code_in    = key_code_ff;
      key_pending_in = key_pending_ff;
      disp_ready_in  = disp_ready_ff;
      result         = '0;
      case (item.mode)
         MODE_READ: begin
            case (item.reg_select)
               REG_PORT_A: begin
                  if (ctrl_a_ff[CTRL_SEL_BIT]) begin
                     result.read_data = {key_pending_ff, key_code_ff};
                     if (key_pending_ff) begin
                        key_pending_in = 1'b0;
                        ctrl_a_in[7]   = 1'b0;
                     end
                  end else begin
                     result.read_data = dir_a_ff;
                  end
               end
               REG_CTRL_A: begin
                  result.read_data = {key_pending_ff, ctrl_a_ff[6:0]};
               end
               REG_PORT_B: begin
                  if (ctrl_b_ff[CTRL_SEL_BIT]) begin
                     result.read_data = {~disp_ready_ff, out_b_ff[6:0]};
                     ctrl_b_in[7]     = 1'b0;
                  end else begin
                     result.read_data = dir_b_ff;
                  end
               end
               default: begin
                  result.read_data = ctrl_b_ff | {disp_ready_ff, 7'b0};
               end
            endcase
         end
         MODE_WRITE: begin
            case (item.reg_select)
               REG_PORT_A: begin
                  // The port A output register is never read back, so only the
                  // direction register needs storage.
                  if (!ctrl_a_ff[CTRL_SEL_BIT]) begin
                     dir_a_in = item.data_in;
                  end
               end
               REG_CTRL_A: begin
                  ctrl_a_in = {ctrl_a_ff[7:6], item.data_in[5:0]};
               end
               REG_PORT_B: begin
                  if (ctrl_b_ff[CTRL_SEL_BIT]) begin
                     out_b_in             = item.data_in;
                     result.display_valid = 1'b1;
                     result.display_char  = item.data_in[6:0];
                     disp_ready_in        = 1'b1;
                  end else begin
                     dir_b_in = item.data_in;
                  end
               end
               default: begin
                  ctrl_b_in = {ctrl_b_ff[7:6], item.data_in[5:0]};
               end
            endcase
         end
         MODE_KEY: begin
            key_code_in    = fold_key(item.data_in);
            key_pending_in = 1'b1;
            ctrl_a_in[7]   = 1'b1;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_a_ff       <= '0;
         ctrl_a_ff      <= '0;
         dir_b_ff       <= '0;
         ctrl_b_ff      <= '0;
         out_b_ff       <= '0;
         key_code_ff    <= '0;
         key_pending_ff <= 1'b0;
         disp_ready_ff  <= 1'b1;
      end else if (fire) begin
         dir_a_ff       <= dir_a_in;
         ctrl_a_ff      <= ctrl_a_in;
         dir_b_ff       <= dir_b_in;
         ctrl_b_ff      <= ctrl_b_in;
         out_b_ff       <= out_b_in;
         key_code_ff    <= key_code_in;
         key_pending_ff <= key_pending_in;
         disp_ready_ff  <= disp_ready_in;
      end
   end

   a_disp_ready: assert property (@(posedge clock) disable iff (reset) disp_ready_ff)
      else $error("Display ready flag was cleared.");

   a_key_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (fire && item.mode == MODE_KEY) |=> key_pending_ff)
      else $error("Key press did not set the pending flag.");

   a_display_no_read: assert property (@(posedge clock) disable iff (reset)
      (fire && result.display_valid) |-> (result.read_data == 8'h00))
      else $error("Display word carries read data.");

   a_ctrl_b_top: assert property (@(posedge clock) disable iff (reset)
      ctrl_b_ff[7:6] == 2'b00)
      else $error("Control B upper bits became set.");

endmodule

`default_nettype wire

// ----- design/keyboard_display_pia_registers.sv -----
// ============================================================================
// keyboard_display_pia_registers: keyboard and display adapter, top level
// Input register, access logic and result register on two stream channels.
// ============================================================================
// Each req word is one event: a bus read, a bus write or a key press, chosen
// by the mode in req_tuser; req_tuser also carries the register index, and
// req_tdata the write value or raw key code. Every event gives exactly one
// rsp word with the read byte, the display flag in rsp_tuser and the
// character sent to the display.
// A word is registered on acceptance and its result is registered when the
// word advances, once the result register is empty or being read out.
// One word is accepted per cycle for as long as rsp_tready stays high; the
// rate is set by the single pass through the register-file logic.
// When the receiver stalls, the result register holds its word and the input
// register takes one more word; req_tready then drops until rsp_tready rises.
// Reset clears both stage valids and puts every kdp_core register at zero
// with the display marked ready.
// ============================================================================
`default_nettype none

module keyboard_display_pia_registers (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_in
   input  wire logic [3:0]  req_tuser,   // mode[1:0], reg_select[3:2]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // read_data[7:0], display_char[14:8], zero
   output      logic        rsp_tuser    // display_valid
);
   import kdp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type core_result;
   logic       advance;
   logic       accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   kdp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= '{data_in: req_tdata, reg_select: req_tuser[3:2], mode: req_tuser[1:0]};
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.display_char, rsp_result_ff.read_data};
   assign rsp_tuser  = rsp_result_ff.display_valid;

endmodule

`default_nettype wire

// ----- test/keyboard_display_pia_registers_tb.sv -----
// ============================================================================
// keyboard_display_pia_registers_tb: self-checking bench for the adapter
// Sends bus reads, bus writes and key presses on the req stream, predicts
// each rsp word from a register-level model kept in the bench, and compares
// every field in order, with random gaps and stalls on both streams.
// ============================================================================
`default_nettype none

module keyboard_display_pia_registers_tb;
   import kdp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_WORDS = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   typedef struct {
      logic [7:0] read_data;
      logic       display_valid;
      logic [6:0] display_char;
   } rsp_fields_type;

   item_type       access_queue[$];
   rsp_fields_type rsp_expected[$];
   int             errors = 0;
   int             idle_cycles = 0;
   int             checked_words = 0;

   // Register image of the adapter.
   logic [7:0]  ddr_a, cr_a, or_a, ddr_b, cr_b, or_b;
   logic [6:0]  kbd_char;
   logic        kbd_strobe, dsp_ready;

   keyboard_display_pia_registers i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic clear_registers();
      ddr_a = '0; cr_a = '0; or_a = '0;
      ddr_b = '0; cr_b = '0; or_b = '0;
      kbd_char = '0;
      kbd_strobe = 1'b0;
      dsp_ready = 1'b1;
   endtask

   task automatic apply_access(input item_type w, output rsp_fields_type r);
      logic [7:0] k;
      r.read_data = '0;
      r.display_valid = 1'b0;
      r.display_char = '0;
      case (w.mode)
         MODE_READ: begin
            case (w.reg_select)
               REG_PORT_A: begin
                  if (cr_a[CTRL_SEL_BIT]) begin
                     r.read_data = {kbd_strobe, kbd_char};
                     if (kbd_strobe) begin
                        kbd_strobe = 1'b0;
                        cr_a[7] = 1'b0;
                     end
                  end else begin
                     r.read_data = ddr_a;
                  end
               end
               REG_CTRL_A: r.read_data = {kbd_strobe, cr_a[6:0]};
               REG_PORT_B: begin
                  if (cr_b[CTRL_SEL_BIT]) begin
                     r.read_data = {~dsp_ready, or_b[6:0]};
                     cr_b[7] = 1'b0;
                  end else begin
                     r.read_data = ddr_b;
                  end
               end
               default: r.read_data = cr_b | {dsp_ready, 7'd0};
            endcase
         end
         MODE_WRITE: begin
            case (w.reg_select)
               REG_PORT_A: begin
                  if (cr_a[CTRL_SEL_BIT]) or_a = w.data_in;
                  else ddr_a = w.data_in;
               end
               REG_CTRL_A: cr_a = {cr_a[7:6], w.data_in[5:0]};
               REG_PORT_B: begin
                  if (cr_b[CTRL_SEL_BIT]) begin
                     or_b = w.data_in;
                     r.display_valid = 1'b1;
                     r.display_char = w.data_in[6:0];
                     dsp_ready = 1'b1;
                  end else begin
                     ddr_b = w.data_in;
                  end
               end
               default: cr_b = {cr_b[7:6], w.data_in[5:0]};
            endcase
         end
         MODE_KEY: begin
            k = w.data_in;
            if (k >= LOWER_FIRST && k <= LOWER_LAST) k = k - CASE_OFFSET;
            if (k == CHAR_LF) k = CHAR_CR;
            kbd_char = k[6:0];
            kbd_strobe = 1'b1;
            cr_a[7] = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic add_access(input logic [1:0] md, input logic [1:0] sel,
                             input logic [7:0] data);
      item_type w;
      w.mode = md;
      w.reg_select = sel;
      w.data_in = data;
      access_queue.push_back(w);
   endtask

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Driver: one word per handshake, random gaps with occasional calm stretches.
   int req_gap = 0;
   int req_calm = 0;
   always @(posedge clock) begin
      rsp_fields_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_registers();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_access(item_type'({req_tdata, req_tuser}), r);
            rsp_expected.push_back(r);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (access_queue.size() > 0) begin
               req_tdata <= access_queue[0].data_in;
               req_tuser <= {access_queue[0].reg_select, access_queue[0].mode};
               req_tvalid <= 1'b1;
               void'(access_queue.pop_front());
               if (req_calm > 0) begin
                  req_calm = req_calm - 1;
               end else if ($urandom_range(0, 59) == 0) begin
                  req_calm = $urandom_range(20, 60);
               end else begin
                  req_gap = draw_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stalls on the rsp side and in-order field checks.
   int rsp_stall = 0;
   int rsp_calm = 0;
   always @(posedge clock) begin
      rsp_fields_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_words++;
            if (rsp_expected.size() == 0) begin
               $display("%0t: unexpected rsp word: expected none, actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_tdata[7:0] !== e.read_data) begin
                  $display("%0t: read_data: expected %h, actual %h",
                           $time, e.read_data, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tuser !== e.display_valid) begin
                  $display("%0t: display_valid: expected %b, actual %b",
                           $time, e.display_valid, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[14:8] !== e.display_char) begin
                  $display("%0t: display_char: expected %h, actual %h",
                           $time, e.display_char, rsp_tdata[14:8]);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_calm > 0) begin
            rsp_calm = rsp_calm - 1;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 59) == 0) begin
            rsp_calm = $urandom_range(20, 60);
            rsp_tready <= 1'b1;
         end else begin
            rsp_stall = draw_gap();
            rsp_tready <= (rsp_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int m;
      int total_words;
      logic [1:0] md;
      logic [7:0] data;

      // Reset state, direction registers, then keyboard folding cases.
      add_access(MODE_READ, REG_CTRL_A, 8'h00);
      add_access(MODE_READ, REG_PORT_A, 8'hFF);
      add_access(MODE_WRITE, REG_PORT_A, 8'hFF);
      add_access(MODE_READ, REG_PORT_A, 8'h00);
      add_access(MODE_WRITE, REG_CTRL_A, 8'hFF);
      add_access(MODE_KEY, REG_CTRL_B, 8'h61);
      add_access(MODE_READ, REG_CTRL_A, 8'h00);
      add_access(MODE_READ, REG_PORT_A, 8'h00);
      add_access(MODE_READ, REG_PORT_A, 8'h00);
      add_access(MODE_KEY, REG_PORT_A, 8'h7A);
      add_access(MODE_KEY, REG_PORT_A, 8'h60);
      add_access(MODE_KEY, REG_PORT_A, 8'h7B);
      add_access(MODE_KEY, REG_PORT_A, 8'h0A);
      add_access(MODE_READ, REG_PORT_A, 8'h00);
      add_access(MODE_KEY, REG_PORT_A, 8'hE1);
      add_access(MODE_READ, REG_PORT_A, 8'h00);
      add_access(MODE_KEY, REG_PORT_A, 8'h00);
      add_access(MODE_WRITE, REG_PORT_A, 8'h55);
      // Port B direction, then data with the display.
      add_access(MODE_WRITE, REG_PORT_B, 8'h80);
      add_access(MODE_READ, REG_PORT_B, 8'h00);
      add_access(MODE_WRITE, REG_CTRL_B, 8'hFF);
      add_access(MODE_READ, REG_CTRL_B, 8'h00);
      add_access(MODE_WRITE, REG_PORT_B, 8'hFF);
      add_access(MODE_WRITE, REG_PORT_B, 8'h00);
      add_access(MODE_READ, REG_PORT_B, 8'h00);
      add_access(MODE_UNUSED, REG_CTRL_B, 8'hFF);
      add_access(MODE_WRITE, REG_CTRL_B, 8'h00);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         m = $urandom_range(0, 99);
         if (m < 35) md = MODE_READ;
         else if (m < 67) md = MODE_WRITE;
         else if (m < 96) md = MODE_KEY;
         else md = MODE_UNUSED;
         m = $urandom_range(0, 9);
         if (m < 2) data = 8'($urandom_range(LOWER_FIRST - 1, LOWER_LAST + 1));
         else if (m < 3) data = CHAR_LF;
         else data = 8'($urandom_range(0, 255));
         add_access(md, 2'($urandom_range(0, 3)), data);
      end
      total_words = access_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (checked_words >= total_words);
      repeat (10) @(posedge clock);
      if (errors == 0 && rsp_expected.size() == 0 && checked_words == total_words) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
